// ===== rtl/mpmr_pkg.sv =====
package mpmr_pkg;

	localparam int NODE_COUNT_DEF      = 256;
	localparam int PATTERN_IDS_DEF     = 256;
	localparam int MAX_PATTERN_LEN_DEF = 32;
	localparam int POSITION_BITS_DEF   = 32;

	localparam int MAX_RESULTS = 32;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_BUILD  = 2'd1;
	localparam logic [1:0] CMD_MATCH  = 2'd2;
	localparam logic [1:0] CMD_START  = 2'd3;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_MATCH    = 2'd1;
	localparam logic [1:0] ST_NOMATCH  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_INS,
		S_EMIT,
		S_B_INIT,
		S_B_DEQ,
		S_B_NODE,
		S_B_SFX,
		S_B_CH,
		S_B_CHD,
		S_B_FRD,
		S_B_FCK,
		S_B_FSL,
		S_B_LINK,
		S_B_WR,
		S_M_FRD,
		S_M_FCK,
		S_M_FSL,
		S_M_WALK,
		S_M_WCHK
	} state_t;

endpackage

// ===== rtl/multi_pattern_match_reporter.sv =====
// Aho-Corasick matcher over bytes; tables live in single-port-read synchronous RAMs. After
// reset the whole child table (NODE_COUNT*256 entries) is swept to zero, with
// item_stall high. Then one transaction is taken at a time: a start, an insert byte, a text
// byte, which follows suffix-link hops and then visits the output chain, or a build, which
// scans the child-table slots of each node in breadth-first order and follows suffix-link
// hops for each child other than those of the root. Results leave through an output
// register, so a stalled result holds the sequencer only when a second result is ready.
module multi_pattern_match_reporter #(
	parameter int NODE_COUNT      = mpmr_pkg::NODE_COUNT_DEF,
	parameter int PATTERN_IDS     = mpmr_pkg::PATTERN_IDS_DEF,
	parameter int MAX_PATTERN_LEN = mpmr_pkg::MAX_PATTERN_LEN_DEF,
	parameter int POSITION_BITS   = mpmr_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        pattern_end,
	input  logic [7:0]  pattern_id,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [31:0] text_position,
	output logic [7:0]  matched_id,
	output logic        last_result
);

	localparam int NB = $clog2(NODE_COUNT);
	localparam int CW = NB + 8;
	localparam int DB = $clog2(MAX_PATTERN_LEN + 1);
	localparam logic [CW-1:0] CLR_LAST = CW'(NODE_COUNT * 256 - 1);
	localparam logic [NB:0] NODE_FULL = (NB+1)'(NODE_COUNT);

	mpmr_pkg::state_t state_q, state_d;

	logic [7:0]    byte_q;
	logic          pend_q;
	logic [7:0]    pid_q;
	logic [NB:0]   count_q;
	logic [NB-1:0] cursor_q;
	logic [DB-1:0] depth_q;
	logic [NB-1:0] cur_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [CW-1:0] clr_q;
	logic [NB:0]   head_q, tail_q;
	logic [NB-1:0] i_q, sfx_q, t_q, s_q, n_q, w_q;
	logic [7:0]    c_q;
	logic [5:0]    nfound_q;
	logic [1:0]    res_status_q;
	logic [POSITION_BITS-1:0] res_pos_q;
	logic [7:0]    res_id_q;

	logic          result_valid_q;
	logic [1:0]    status_q;
	logic [31:0]   text_position_q;
	logic [7:0]    matched_id_q;
	logic          last_result_q;

	logic          ch_we;
	logic [CW-1:0] ch_waddr, ch_raddr;
	logic [NB-1:0] ch_wdata, ch_rdata;
	logic          pat_we;
	logic [NB-1:0] pat_waddr, pat_raddr;
	logic [8:0]    pat_wdata, pat_rdata;
	logic          lnk_we;
	logic [NB-1:0] lnk_waddr, sfx_raddr, sfx_rdata, out_wdata, out_rdata;
	logic          q_we;
	logic [NB-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

	logic          emit_ok, out_load, out_last, accept;
	logic          depth_full, new_node, ok_byte, pid_ok, ok_final, grow;
	logic [NB-1:0] t_sel, cursor_after;
	logic          wchk_hold;

	assign emit_ok = !result_valid_q || !result_stall;
	assign accept  = item_valid && (state_q == mpmr_pkg::S_IDLE);

	assign depth_full   = depth_q >= DB'(MAX_PATTERN_LEN);
	assign new_node     = ch_rdata == '0;
	assign ok_byte      = !depth_full && !(new_node && (count_q >= NODE_FULL));
	assign grow         = !depth_full && new_node && (count_q < NODE_FULL);
	assign t_sel        = new_node ? count_q[NB-1:0] : ch_rdata;
	assign cursor_after = ok_byte ? t_sel : cursor_q;
	assign pid_ok       = 32'(pid_q) < PATTERN_IDS;
	assign ok_final     = ok_byte && (!pend_q || pid_ok);
	assign wchk_hold    = pat_rdata[8] && (nfound_q != '0) && !emit_ok;

	mpmr_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT * 256)) u_child (
		.clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
		.raddr(ch_raddr), .rdata(ch_rdata)
	);
	mpmr_ram #(.WIDTH(9), .DEPTH(NODE_COUNT)) u_pattern (
		.clk(clk), .we(pat_we), .waddr(pat_waddr), .wdata(pat_wdata),
		.raddr(pat_raddr), .rdata(pat_rdata)
	);
	mpmr_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_suffix (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(s_q),
		.raddr(sfx_raddr), .rdata(sfx_rdata)
	);
	mpmr_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_outlink (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(out_wdata),
		.raddr(pat_raddr), .rdata(out_rdata)
	);
	mpmr_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpmr_pkg::S_CLR: begin
				if (clr_q == CLR_LAST) state_d = mpmr_pkg::S_IDLE;
			end
			mpmr_pkg::S_IDLE: begin
				if (item_valid) begin
					case (command)
						mpmr_pkg::CMD_INSERT: state_d = mpmr_pkg::S_INS;
						mpmr_pkg::CMD_BUILD:  state_d = mpmr_pkg::S_B_INIT;
						mpmr_pkg::CMD_MATCH:  state_d = mpmr_pkg::S_M_FRD;
						default:              state_d = mpmr_pkg::S_EMIT;
					endcase
				end
			end
			mpmr_pkg::S_INS:    state_d = mpmr_pkg::S_EMIT;
			mpmr_pkg::S_EMIT: begin
				if (emit_ok) state_d = mpmr_pkg::S_IDLE;
			end
			mpmr_pkg::S_B_INIT: state_d = mpmr_pkg::S_B_DEQ;
			mpmr_pkg::S_B_DEQ: begin
				state_d = (head_q == tail_q) ? mpmr_pkg::S_EMIT : mpmr_pkg::S_B_NODE;
			end
			mpmr_pkg::S_B_NODE: state_d = mpmr_pkg::S_B_SFX;
			mpmr_pkg::S_B_SFX:  state_d = mpmr_pkg::S_B_CH;
			mpmr_pkg::S_B_CH:   state_d = mpmr_pkg::S_B_CHD;
			mpmr_pkg::S_B_CHD: begin
				if (ch_rdata == '0) begin
					state_d = (c_q == 8'hff) ? mpmr_pkg::S_B_DEQ : mpmr_pkg::S_B_CH;
				end else begin
					state_d = (i_q == '0) ? mpmr_pkg::S_B_LINK : mpmr_pkg::S_B_FRD;
				end
			end
			mpmr_pkg::S_B_FRD:  state_d = mpmr_pkg::S_B_FCK;
			mpmr_pkg::S_B_FCK: begin
				if (ch_rdata != '0 || n_q == '0) state_d = mpmr_pkg::S_B_LINK;
				else state_d = mpmr_pkg::S_B_FSL;
			end
			mpmr_pkg::S_B_FSL:  state_d = mpmr_pkg::S_B_FRD;
			mpmr_pkg::S_B_LINK: state_d = mpmr_pkg::S_B_WR;
			mpmr_pkg::S_B_WR: begin
				state_d = (c_q == 8'hff) ? mpmr_pkg::S_B_DEQ : mpmr_pkg::S_B_CH;
			end
			mpmr_pkg::S_M_FRD:  state_d = mpmr_pkg::S_M_FCK;
			mpmr_pkg::S_M_FCK: begin
				if (ch_rdata != '0 || n_q == '0) state_d = mpmr_pkg::S_M_WALK;
				else state_d = mpmr_pkg::S_M_FSL;
			end
			mpmr_pkg::S_M_FSL:  state_d = mpmr_pkg::S_M_FRD;
			mpmr_pkg::S_M_WALK: begin
				if (w_q == '0 || nfound_q == 6'(mpmr_pkg::MAX_RESULTS)) begin
					state_d = mpmr_pkg::S_EMIT;
				end else begin
					state_d = mpmr_pkg::S_M_WCHK;
				end
			end
			mpmr_pkg::S_M_WCHK: begin
				if (!wchk_hold) state_d = mpmr_pkg::S_M_WALK;
			end
			default: state_d = mpmr_pkg::S_IDLE;
		endcase
	end

	// memory ports and result loading
	always_comb begin
		item_stall = state_q != mpmr_pkg::S_IDLE;
		ch_we      = 1'b0;
		ch_waddr   = clr_q;
		ch_wdata   = '0;
		ch_raddr   = '0;
		pat_we     = 1'b0;
		pat_waddr  = clr_q[NB-1:0];
		pat_wdata  = '0;
		pat_raddr  = w_q;
		lnk_we     = 1'b0;
		lnk_waddr  = t_q;
		out_wdata  = pat_rdata[8] ? s_q : out_rdata;
		sfx_raddr  = n_q;
		q_we       = 1'b0;
		q_waddr    = tail_q[NB-1:0];
		q_wdata    = t_q;
		q_raddr    = head_q[NB-1:0];
		out_load   = 1'b0;
		out_last   = 1'b1;
		case (state_q)
			mpmr_pkg::S_CLR: begin
				ch_we  = 1'b1;
				pat_we = clr_q < CW'(NODE_COUNT);
			end
			mpmr_pkg::S_IDLE: ch_raddr = {cursor_q, data_byte};
			mpmr_pkg::S_INS: begin
				ch_we     = grow;
				ch_waddr  = {cursor_q, byte_q};
				ch_wdata  = count_q[NB-1:0];
				pat_we    = pend_q && ok_byte && pid_ok;
				pat_waddr = cursor_after;
				pat_wdata = {1'b1, pid_q};
			end
			mpmr_pkg::S_EMIT: out_load = emit_ok;
			mpmr_pkg::S_B_INIT: begin
				lnk_we    = 1'b1;
				lnk_waddr = '0;
				out_wdata = '0;
				q_we      = 1'b1;
				q_waddr   = '0;
				q_wdata   = '0;
			end
			mpmr_pkg::S_B_NODE: sfx_raddr = q_rdata;
			mpmr_pkg::S_B_CH:   ch_raddr = {i_q, c_q};
			mpmr_pkg::S_B_FRD:  ch_raddr = {n_q, c_q};
			mpmr_pkg::S_B_LINK: pat_raddr = s_q;
			mpmr_pkg::S_B_WR: begin
				lnk_we = 1'b1;
				q_we   = tail_q < NODE_FULL;
			end
			mpmr_pkg::S_M_FRD:  ch_raddr = {n_q, byte_q};
			mpmr_pkg::S_M_WCHK: begin
				out_load = pat_rdata[8] && (nfound_q != '0) && emit_ok;
				out_last = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mpmr_pkg::S_CLR;
			clr_q    <= '0;
			count_q  <= (NB+1)'(1);
			cursor_q <= '0;
			depth_q  <= '0;
			cur_q    <= '0;
			pos_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			nfound_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
			case (state_q)
				mpmr_pkg::S_CLR: clr_q <= clr_q + 1'b1;
				mpmr_pkg::S_IDLE: begin
					if (accept && command == mpmr_pkg::CMD_MATCH) begin
						pos_q    <= pos_q + 1'b1;
						n_q      <= cur_q;
						nfound_q <= '0;
					end else if (accept && command == mpmr_pkg::CMD_START) begin
						pos_q <= '0;
						cur_q <= '0;
					end
				end
				mpmr_pkg::S_INS: begin
					if (grow) count_q <= count_q + 1'b1;
					if (pend_q) begin
						cursor_q <= '0;
						depth_q  <= '0;
					end else if (ok_byte) begin
						cursor_q <= t_sel;
						depth_q  <= depth_q + 1'b1;
					end
				end
				mpmr_pkg::S_B_INIT: begin
					head_q <= '0;
					tail_q <= (NB+1)'(1);
				end
				mpmr_pkg::S_B_DEQ: begin
					if (head_q != tail_q) head_q <= head_q + 1'b1;
				end
				mpmr_pkg::S_B_NODE: i_q <= q_rdata;
				mpmr_pkg::S_B_SFX: begin
					sfx_q <= sfx_rdata;
					c_q   <= '0;
				end
				mpmr_pkg::S_B_CHD: begin
					if (ch_rdata == '0) begin
						c_q <= c_q + 1'b1;
					end else begin
						t_q <= ch_rdata;
						s_q <= '0;
						n_q <= sfx_q;
					end
				end
				mpmr_pkg::S_B_FCK: begin
					if (ch_rdata != '0) s_q <= ch_rdata;
					else if (n_q == '0) s_q <= '0;
				end
				mpmr_pkg::S_B_FSL: n_q <= sfx_rdata;
				mpmr_pkg::S_B_WR: begin
					c_q <= c_q + 1'b1;
					if (tail_q < NODE_FULL) tail_q <= tail_q + 1'b1;
				end
				mpmr_pkg::S_M_FCK: begin
					if (ch_rdata != '0) begin
						cur_q <= ch_rdata;
						w_q   <= ch_rdata;
					end else if (n_q == '0) begin
						cur_q <= '0;
						w_q   <= '0;
					end
				end
				mpmr_pkg::S_M_FSL: n_q <= sfx_rdata;
				mpmr_pkg::S_M_WCHK: begin
					if (!wchk_hold) begin
						w_q <= out_rdata;
						if (pat_rdata[8]) nfound_q <= nfound_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q       <= data_byte;
			pend_q       <= pattern_end;
			pid_q        <= pattern_id;
			res_id_q     <= '0;
			res_pos_q    <= (command == mpmr_pkg::CMD_MATCH) ? pos_q : '0;
			res_status_q <= (command == mpmr_pkg::CMD_MATCH) ? mpmr_pkg::ST_NOMATCH
			                                                 : mpmr_pkg::ST_DONE;
		end
		if (state_q == mpmr_pkg::S_INS) begin
			res_status_q <= ok_final ? mpmr_pkg::ST_DONE : mpmr_pkg::ST_OVERFLOW;
		end
		if (state_q == mpmr_pkg::S_M_WCHK && !wchk_hold && pat_rdata[8]) begin
			res_id_q     <= pat_rdata[7:0];
			res_status_q <= mpmr_pkg::ST_MATCH;
		end
		if (out_load) begin
			status_q        <= res_status_q;
			text_position_q <= 32'(res_pos_q);
			matched_id_q    <= res_id_q;
			last_result_q   <= out_last;
		end
	end

	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign text_position = text_position_q;
	assign matched_id    = matched_id_q;
	assign last_result   = last_result_q;

endmodule

// ===== rtl/mpmr_ram.sv =====
module mpmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mpmr_checker.sv =====
module mpmr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  status,
	input logic [31:0] text_position,
	input logic [7:0]  matched_id,
	input logic        last_result
);

	// one transaction at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while previous one in progress");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(matched_id) && $stable(last_result))
		else $error("stalled result changed");

	a_single_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != mpmr_pkg::ST_MATCH |-> last_result)
		else $error("non-match result not final");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == mpmr_pkg::ST_DONE || status == mpmr_pkg::ST_OVERFLOW)
			|-> text_position == '0 && matched_id == '0)
		else $error("control result carries position or id");

endmodule

bind multi_pattern_match_reporter mpmr_checker u_mpmr_checker (.*);

// ===== verif/match_checker.sv =====
`timescale 1ns / 1ps

module match_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        pattern_end,
	input  logic [7:0]  pattern_id,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [1:0]  status,
	input  logic [31:0] text_position,
	input  logic [7:0]  matched_id,
	input  logic        last_result,
	output int          fail_count,
	output int          pending,
	output int          node_total,
	output int          hit_total
);

	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] pos;
		logic [7:0]  id;
		logic        last;
	} report_t;

	report_t     report_q[$];
	logic [7:0]  trie_kid [0:65535];
	logic [7:0]  fail_lnk [0:255];
	logic [7:0]  dict_lnk [0:255];
	logic [8:0]  node_pat [0:255];
	int          nodes;
	logic [7:0]  cursor;
	int          depth;
	logic [7:0]  text_node;
	logic [31:0] text_pos;

	task automatic report_error(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic void add_report(input report_t r);
		report_q.insert(report_q.size(), r);
	endfunction

	function automatic logic [7:0] goto_next(input logic [7:0] n, input logic [7:0] c);
		logic [7:0] t;
		for (int k = 0; k <= 256; k++) begin
			t = trie_kid[{n, c}];
			if (t != 0) return t;
			if (n == 0) return 8'd0;
			n = fail_lnk[n];
		end
		return 8'd0;
	endfunction

	task automatic build_links();
		int         q[$];
		logic [7:0] i, t, s;
		fail_lnk[0] = 0;
		dict_lnk[0] = 0;
		q.insert(q.size(), 0);
		while (q.size() > 0) begin
			i = 8'(q.pop_front());
			for (int c = 0; c < 256; c++) begin
				t = trie_kid[{i, 8'(c)}];
				if (t == 0) continue;
				s = (i == 0) ? 8'd0 : goto_next(fail_lnk[i], 8'(c));
				fail_lnk[t] = s;
				dict_lnk[t] = node_pat[s][8] ? s : dict_lnk[s];
				q.insert(q.size(), int'(t));
			end
		end
	endtask

	task automatic predict_insert(input logic [7:0] b, input logic e, input logic [7:0] id);
		logic       ok;
		logic [7:0] t;
		ok = 1'b1;
		if (depth >= mpmr_pkg::MAX_PATTERN_LEN_DEF) begin
			ok = 1'b0;
		end else begin
			t = trie_kid[{cursor, b}];
			if (t == 0) begin
				if (nodes >= mpmr_pkg::NODE_COUNT_DEF) begin
					ok = 1'b0;
				end else begin
					t = 8'(nodes);
					nodes++;
					trie_kid[{cursor, b}] = t;
				end
			end
			if (ok) begin
				cursor = t;
				depth++;
			end
		end
		if (e) begin
			if (ok && 32'(id) < mpmr_pkg::PATTERN_IDS_DEF) node_pat[cursor] = {1'b1, id};
			else ok = 1'b0;
			cursor = 0;
			depth = 0;
		end
		add_report('{ok ? mpmr_pkg::ST_DONE : mpmr_pkg::ST_OVERFLOW, 32'd0, 8'd0, 1'b1});
	endtask

	task automatic predict_text_byte(input logic [7:0] b);
		logic [31:0] p;
		logic [7:0]  w;
		report_t     r;
		int          n;
		p = text_pos;
		text_pos = text_pos + 1;
		text_node = goto_next(text_node, b);
		w = text_node;
		n = 0;
		while (w != 0 && n < mpmr_pkg::MAX_RESULTS) begin
			if (node_pat[w][8]) begin
				add_report('{mpmr_pkg::ST_MATCH, p, node_pat[w][7:0], 1'b0});
				n++;
			end
			w = dict_lnk[w];
		end
		if (n == 0) begin
			add_report('{mpmr_pkg::ST_NOMATCH, p, 8'd0, 1'b1});
		end else begin
			r = report_q.pop_back();
			r.last = 1'b1;
			add_report(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t e;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++) trie_kid[i] = 0;
			for (int i = 0; i < 256; i++) begin
				fail_lnk[i] = 0;
				dict_lnk[i] = 0;
				node_pat[i] = 0;
			end
			nodes = 1;
			cursor = 0;
			depth = 0;
			text_node = 0;
			text_pos = 0;
			fail_count = 0;
			hit_total = 0;
			report_q.delete();
		end else begin
			if (item_valid && !item_stall) begin
				case (command)
					mpmr_pkg::CMD_INSERT: predict_insert(data_byte, pattern_end, pattern_id);
					mpmr_pkg::CMD_BUILD: begin
						build_links();
						add_report('{mpmr_pkg::ST_DONE, 32'd0, 8'd0, 1'b1});
					end
					mpmr_pkg::CMD_MATCH: predict_text_byte(data_byte);
					mpmr_pkg::CMD_START: begin
						text_node = 0;
						text_pos = 0;
						add_report('{mpmr_pkg::ST_DONE, 32'd0, 8'd0, 1'b1});
					end
					default: begin
					end
				endcase
			end
			if (result_valid && !result_stall) begin
				if (report_q.size() == 0) begin
					report_error("unexpected transaction, status", 32'(status), 32'd0);
				end else begin
					e = report_q.pop_front();
					if (status == mpmr_pkg::ST_MATCH) hit_total++;
					if (status !== e.st) report_error("status", 32'(status), 32'(e.st));
					if (text_position !== e.pos)
						report_error("text_position", text_position, e.pos);
					if (matched_id !== e.id)
						report_error("matched_id", 32'(matched_id), 32'(e.id));
					if (last_result !== e.last)
						report_error("last_result", 32'(last_result), 32'(e.last));
				end
			end
		end
		pending = report_q.size();
		node_total = nodes;
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic        pattern_end;
	logic [7:0]  pattern_id;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  status;
	logic [31:0] text_position;
	logic [7:0]  matched_id;
	logic        last_result;
	int          fail_count;
	int          pending;
	int          node_total;
	int          hit_total;
	int          cycles;
	int          item_total;
	int          stall_burst;
	bit          quiet;

	multi_pattern_match_reporter u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .data_byte(data_byte),
		.pattern_end(pattern_end), .pattern_id(pattern_id),
		.result_valid(result_valid), .result_stall(result_stall),
		.status(status), .text_position(text_position),
		.matched_id(matched_id), .last_result(last_result)
	);

	match_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.command(command), .data_byte(data_byte),
		.pattern_end(pattern_end), .pattern_id(pattern_id),
		.result_valid(result_valid), .result_stall(result_stall),
		.status(status), .text_position(text_position),
		.matched_id(matched_id), .last_result(last_result),
		.fail_count(fail_count), .pending(pending),
		.node_total(node_total), .hit_total(hit_total)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[multi_pattern_match_reporter] ERROR");
			$finish;
		end
	end

	// random result backpressure in bursts
	always @(negedge clk) begin
		if (quiet) begin
			result_stall = 1'b0;
			stall_burst = 0;
		end else if (stall_burst > 0) begin
			stall_burst--;
			result_stall = 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_burst = $urandom_range(0, 17);
			result_stall = 1'b1;
		end else begin
			result_stall = 1'b0;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_item(input logic [1:0] c, input logic [7:0] b, input logic e,
			input logic [7:0] id);
		bit taken;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item_valid = 1'b1;
		command = c;
		data_byte = b;
		pattern_end = e;
		pattern_id = id;
		do begin
			taken = !item_stall;
			@(negedge clk);
		end while (!taken);
		item_total++;
	endtask

	task automatic push_word(input string s, input logic [7:0] id);
		for (int i = 0; i < s.len(); i++)
			push_item(mpmr_pkg::CMD_INSERT, s[i], i == s.len() - 1, id);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_item(mpmr_pkg::CMD_MATCH, s[i], 1'b0, 8'd0);
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0) return 8'($urandom());
		return 8'("a" + $urandom_range(0, 3));
	endfunction

	initial begin
		int len;
		cycles = 0;
		item_total = 0;
		stall_burst = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		command = mpmr_pkg::CMD_START;
		data_byte = 8'd0;
		pattern_end = 1'b0;
		pattern_id = 8'd0;
		result_stall = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed: classic dictionary, overwrite, extreme bytes and ids
		push_word("he", 8'd1);
		push_word("she", 8'd2);
		push_word("his", 8'd3);
		push_word("hers", 8'd4);
		push_word("he", 8'h55);
		push_item(mpmr_pkg::CMD_INSERT, 8'h00, 1'b1, 8'h00);
		push_item(mpmr_pkg::CMD_INSERT, 8'hff, 1'b1, 8'hff);
		push_item(mpmr_pkg::CMD_BUILD, 8'hff, 1'b1, 8'hff);
		push_item(mpmr_pkg::CMD_START, 8'd0, 1'b0, 8'd0);
		push_text("ushers");
		push_item(mpmr_pkg::CMD_MATCH, 8'h00, 1'b1, 8'hff);
		push_item(mpmr_pkg::CMD_MATCH, 8'hff, 1'b0, 8'h00);
		push_item(mpmr_pkg::CMD_START, 8'hff, 1'b1, 8'hff);
		push_text("h");

		// random rounds of insert, build, start, text
		for (int r = 0; r < 4; r++) begin
			repeat ($urandom_range(3, 6)) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					push_item(mpmr_pkg::CMD_INSERT, pick_byte(),
						(i == len - 1) && ($urandom_range(0, 9) != 0), 8'($urandom()));
			end
			if (r == 2)
				for (int i = 0; i < 34; i++)
					push_item(mpmr_pkg::CMD_INSERT, 8'($urandom()), i >= 32, 8'($urandom()));
			push_item(mpmr_pkg::CMD_BUILD, 8'($urandom()), 1'($urandom()), 8'($urandom()));
			push_item(mpmr_pkg::CMD_START, 8'($urandom()), 1'($urandom()), 8'($urandom()));
			repeat (6) begin
				if ($urandom_range(0, 19) == 0)
					push_item(mpmr_pkg::CMD_START, 8'($urandom()), 1'($urandom()),
						8'($urandom()));
				else
					push_item(mpmr_pkg::CMD_MATCH, pick_byte(), 1'($urandom()),
						8'($urandom()));
			end
		end

		// no idling from here: fill the node table and run past it
		quiet = 1'b1;
		while (node_total < mpmr_pkg::NODE_COUNT_DEF)
			push_item(mpmr_pkg::CMD_INSERT, 8'($urandom()), $urandom_range(0, 7) == 0,
				8'($urandom()));
		for (int i = 0; i < 4; i++)
			push_item(mpmr_pkg::CMD_INSERT, 8'($urandom()), i == 3, 8'($urandom()));
		push_item(mpmr_pkg::CMD_BUILD, 8'd0, 1'b0, 8'd0);
		push_item(mpmr_pkg::CMD_START, 8'd0, 1'b0, 8'd0);
		repeat (10) push_item(mpmr_pkg::CMD_MATCH, pick_byte(), 1'b0, 8'd0);

		item_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("sent %0d transactions, %0d trie nodes, %0d pattern hits reported",
			item_total, node_total, hit_total);
		if (fail_count == 0) begin
			$display("[multi_pattern_match_reporter] OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("[multi_pattern_match_reporter] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mpmr_pkg.sv
rtl/mpmr_ram.sv
rtl/multi_pattern_match_reporter.sv
rtl/mpmr_checker.sv
verif/match_checker.sv
verif/testbench.sv
